// File: rtl/core/isut_pkg.sv
// Package: transaction payload types, action codes and sequencer states for the set table.
package isut_pkg;

   localparam int FIELD_W = 7;

   localparam logic [2:0] ACT_INSERT  = 3'd0;
   localparam logic [2:0] ACT_REMOVE  = 3'd1;
   localparam logic [2:0] ACT_MEMBER  = 3'd2;
   localparam logic [2:0] ACT_GREATER = 3'd3;
   localparam logic [2:0] ACT_LESS    = 3'd4;
   localparam logic [2:0] ACT_CLEAR   = 3'd5;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               success;
      logic [FIELD_W-1:0] match_count;
      logic [FIELD_W-1:0] set_size;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN,
      ST_MOVE_RD,
      ST_MOVE_WR
   } state_type;

endpackage

// File: rtl/core/isut_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module isut_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/isut_engine.sv
// Scan sequencer: walks the element store, updates it and forms each result.
module isut_engine #(
   parameter int CAPACITY = 64,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  isut_pkg::req_type req_data,
   output logic             req_stall,
   output logic             res_valid,
   output isut_pkg::rsp_type res_data,
   input  logic             res_take,
   output logic             mem_wr_en,
   output logic [AW-1:0]    mem_wr_addr,
   output logic [31:0]      mem_wr_data,
   output logic [AW-1:0]    mem_rd_addr,
   input  logic [31:0]      mem_rd_data
);
   import isut_pkg::*;

   localparam int EW = (CW > FIELD_W) ? CW : FIELD_W;

   function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
      logic [EW-1:0] e;
      e = EW'(v);
      return e[FIELD_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [2:0]         act_ff, act_in;
   logic signed [31:0] val_ff, val_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [CW-1:0]      issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      ridx_ff, ridx_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      count_ff, count_in;

   logic [CW-1:0]      tot_new;
   logic               ok;
   logic [CW-1:0]      cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      val_ff   <= val_in;
      issue_ff <= issue_in;
      pend_ff  <= pend_in;
      ridx_ff  <= ridx_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      count_ff <= count_in;
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      val_in      = val_ff;
      total_in    = total_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      ridx_in     = ridx_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      req_stall   = (state_ff != ST_IDLE);
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = total_ff[AW-1:0];
      mem_wr_data = val_ff;
      mem_rd_addr = issue_ff[AW-1:0];
      tot_new     = total_ff;
      ok          = 1'b0;
      cnt         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in   = req_data.action;
               val_in   = req_data.value;
               issue_in = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               count_in = '0;
               if ((total_ff != '0) &&
                   (req_data.action inside {ACT_INSERT, ACT_REMOVE, ACT_MEMBER,
                                            ACT_GREATER, ACT_LESS})) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SCAN: begin
            // compare the word read in the previous cycle
            if (pend_ff) begin
               if (mem_rd_data == val_ff) begin
                  found_in = 1'b1;
                  slot_in  = ridx_ff;
               end
               if ((act_ff == ACT_GREATER && $signed(mem_rd_data) > val_ff) ||
                   (act_ff == ACT_LESS && $signed(mem_rd_data) < val_ff)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (issue_ff < total_ff) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
               ridx_in  = issue_ff[AW-1:0];
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (act_ff == ACT_REMOVE && found_ff) begin
               state_in = ST_MOVE_RD;
            end else begin
               res_valid = 1'b1;
               unique case (act_ff) inside
                  ACT_INSERT: begin
                     if (!found_ff && total_ff < CW'(CAPACITY)) begin
                        ok        = 1'b1;
                        tot_new   = total_ff + 1'b1;
                        mem_wr_en = res_take;
                     end
                  end
                  ACT_MEMBER: ok = found_ff;
                  ACT_GREATER, ACT_LESS: begin
                     cnt = (count_ff == total_ff) ? '0 : count_ff;
                  end
                  ACT_CLEAR: tot_new = '0;
                  default: ;
               endcase
               if (res_take) begin
                  total_in = tot_new;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MOVE_RD: begin
            mem_rd_addr = AW'(total_ff - 1'b1);
            state_in    = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            // last element moves into the freed slot
            mem_rd_addr = AW'(total_ff - 1'b1);
            mem_wr_addr = slot_ff;
            mem_wr_data = mem_rd_data;
            res_valid   = 1'b1;
            ok          = 1'b1;
            tot_new     = total_ff - 1'b1;
            mem_wr_en   = res_take;
            if (res_take) begin
               total_in = tot_new;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      res_data.success     = ok;
      res_data.match_count = to_field(cnt);
      res_data.set_size    = to_field(tot_new);
      res_data.is_empty    = (tot_new == '0);
      res_data.is_full     = (tot_new == CW'(CAPACITY));
   end

endmodule

// File: rtl/core/integer_set_table_unit.sv
// Top level of the set table: element store, scan sequencer and result register.
//
// A set of distinct signed 32-bit integers held unsorted in a CAPACITY-deep RAM.
// Request channel (req_valid / req_stall / req_data): one transaction carries an
// action (insert, remove, member, count greater, count less, clear) and a value.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one transaction per
// request with success, match_count, set_size, is_empty and is_full.
// The sequencer reads one stored element per cycle through the RAM's registered
// read port and compares each returned word with the request value; a remove that
// hits then fetches the last element and moves it into the freed slot.
// Clear, unused codes and actions on an empty set skip the scan and finish at once.
// One request is worked on at a time; req_stall is high from acceptance until the
// result enters the response register.
// The response register parts the two sides: a new request is taken while an
// earlier result still waits on rsp_stall. A finished result that finds the
// register full holds the sequencer until it drains.
// Reset (synchronous, active high) empties the set, returns the sequencer to idle
// and clears rsp_valid; the RAM itself is not cleared, since only slots below the
// element count are read.
module integer_set_table_unit #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  isut_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output isut_pkg::rsp_type rsp_data
);
   import isut_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic          res_valid;
   rsp_type       res_data;
   logic          res_take;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   isut_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   isut_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_take    (res_take),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // register can load when empty or when its transaction completes this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/isut_checker.sv
// Port-level checker for the set table, bound to the top level.
module isut_checker #(
   parameter int CAPACITY = 64
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input isut_pkg::rsp_type rsp_data
);
   import isut_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one request in flight: acceptance closes the request channel
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in progress");

   // success and a nonzero count never come from the same action
   a_ok_xor_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.success && rsp_data.match_count != '0))
      else $error("success with nonzero count");

   // size and empty flag agree while the size field is not wrapped
   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (CAPACITY < 128) |-> rsp_data.is_empty == (rsp_data.set_size == '0))
      else $error("empty flag disagrees with size");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_full |-> !rsp_data.is_empty)
      else $error("full and empty at once");

endmodule

bind integer_set_table_unit isut_checker #(.CAPACITY(CAPACITY)) u_isut_checker (.*);
